/* hdl/assert_macros.svh */
// assertion macros shared by the packer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define HCBP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// expression must never be true outside reset
`define HCBP_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

/* hdl/hcbp_pkg.sv */
// shared types and constants of the huffman code bit packer
package hcbp_pkg;

   localparam int BYTE_W    = 8;
   localparam int PEND_W    = 7;
   localparam int PCNT_W    = 3;
   localparam int NBYTE_W   = 3;
   localparam int TOTAL_W   = 32;
   localparam int SYMBOL_W  = 8;
   localparam int WORD_W    = 32;
   localparam int LENGTH_W  = 6;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   // item held in the lookup stage while its table read completes
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
      logic    hit;
   } lookup_type;

   // work handed from the packing stage to the byte emitter
   typedef struct packed {
      logic                 take;
      logic [NBYTE_W-1:0]   nbytes;
   } emit_req_type;

endpackage

/* hdl/hcbp_table.sv */
// code table memory with length valid bits and the lookup stage register
`include "assert_macros.svh"

module hcbp_table #(
   parameter int NUM_SYMBOLS = 256,
   parameter int CODE_W      = 32,
   parameter int LEN_W       = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [hcbp_pkg::SYMBOL_W-1:0] req_symbol,
   input  logic [hcbp_pkg::WORD_W-1:0]   req_code_word,
   input  logic [hcbp_pkg::LENGTH_W-1:0] req_code_length,
   input  logic                          advance,
   output hcbp_pkg::lookup_type          lookup,
   output logic [CODE_W-1:0]             lookup_code,
   output logic [LEN_W-1:0]              lookup_len
);
   import hcbp_pkg::*;

   localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int ENTRY_W = CODE_W + LEN_W;

   logic [ENTRY_W-1:0]     mem [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0] written_ff;
   logic [ENTRY_W-1:0]     rd_ff;
   lookup_type             lookup_ff, lookup_in;

   logic                   accept;
   logic                   sym_ok;
   logic [SYM_W-1:0]       idx;
   cmd_type                cmd;
   logic [LEN_W-1:0]       len_clamped;

   assign cmd    = cmd_type'(req_cmd);
   assign sym_ok = {1'b0, req_symbol} < 9'(NUM_SYMBOLS);
   assign idx    = req_symbol[SYM_W-1:0];

   assign req_ready = !lookup_ff.valid || advance;
   assign accept    = req_valid && req_ready;

   // lengths beyond the code limit behave as the limit
   assign len_clamped = (req_code_length > LENGTH_W'(CODE_W)) ?
                        LEN_W'(CODE_W) : LEN_W'(req_code_length);

   always_ff @(posedge clock) begin
      if (accept && cmd == CMD_LOAD && sym_ok) begin
         mem[idx] <= {req_code_word[CODE_W-1:0], len_clamped};
      end
      if (accept) begin
         rd_ff <= mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (accept && cmd == CMD_LOAD && sym_ok) begin
         written_ff[idx] <= 1'b1;
      end
   end

   always_comb begin
      lookup_in = lookup_ff;
      if (accept) begin
         lookup_in.valid = 1'b1;
         lookup_in.cmd   = cmd;
         lookup_in.hit   = (cmd == CMD_ENCODE) && sym_ok && written_ff[idx];
      end else if (advance) begin
         lookup_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_ff <= '0;
      end else begin
         lookup_ff <= lookup_in;
      end
   end

   assign lookup      = lookup_ff;
   assign lookup_code = rd_ff[ENTRY_W-1:LEN_W];
   assign lookup_len  = rd_ff[LEN_W-1:0];

   `HCBP_ASSERT(a_hit_encode,
      lookup_ff.hit && lookup_ff.valid |-> lookup_ff.cmd == CMD_ENCODE,
      "table hit on a non-encode item")
   `HCBP_ASSERT(a_stall_holds,
      lookup_ff.valid && !advance |=> lookup_ff.valid && rd_ff === $past(rd_ff),
      "stalled lookup lost its read data")

endmodule

/* hdl/hcbp_pack.sv */
// bit accumulator: appends codes to pending bits and cuts out whole bytes
`include "assert_macros.svh"

module hcbp_pack #(
   parameter int CODE_W = 32,
   parameter int LEN_W  = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hcbp_pkg::lookup_type         lookup,
   input  logic [CODE_W-1:0]            lookup_code,
   input  logic [LEN_W-1:0]             lookup_len,
   input  logic                         emit_free,
   output logic                         advance,
   output hcbp_pkg::emit_req_type       emit_req,
   output logic [CODE_W+6:0]            emit_win,
   output logic [hcbp_pkg::TOTAL_W-1:0] emit_total
);
   import hcbp_pkg::*;

   localparam int WIN_W = CODE_W + PEND_W;
   localparam int CNT_W = $clog2(WIN_W + 1);

   logic [PEND_W-1:0]  pend_ff, pend_in;
   logic [PCNT_W-1:0]  pcnt_ff, pcnt_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               is_enc, is_flush;
   logic [LEN_W-1:0]   len_eff;
   logic [WIN_W-1:0]   acc;
   logic [CNT_W-1:0]   count;
   logic [PCNT_W-1:0]  rem;
   logic [NBYTE_W-1:0] nbytes;
   logic [PEND_W-1:0]  pend_keep;

   assign is_enc   = lookup.cmd == CMD_ENCODE;
   assign is_flush = lookup.cmd == CMD_FLUSH;
   assign len_eff  = lookup.hit ? lookup_len : '0;

   // a flush uses the same path with no new code bits
   assign acc   = (WIN_W'(pend_ff) << len_eff)
                | (WIN_W'(lookup_code) & ~({WIN_W{1'b1}} << len_eff));
   assign count = CNT_W'(pcnt_ff) + CNT_W'(len_eff);
   assign rem   = count[PCNT_W-1:0];
   assign pend_keep = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);

   always_comb begin
      nbytes = '0;
      if (is_enc) begin
         nbytes = NBYTE_W'(count >> 3);
      end else if (is_flush && pcnt_ff != '0) begin
         nbytes = NBYTE_W'(1);
      end
   end

   // left align so the earliest bit sits at the top of the window
   assign emit_win = acc << (CNT_W'(WIN_W) - count);

   assign advance         = lookup.valid && (nbytes == '0 || emit_free);
   assign emit_req.take   = advance && nbytes != '0;
   assign emit_req.nbytes = nbytes;

   always_comb begin
      pend_in  = pend_ff;
      pcnt_in  = pcnt_ff;
      total_in = total_ff;
      if (is_enc) begin
         pend_in  = pend_keep;
         pcnt_in  = rem;
         total_in = total_ff + TOTAL_W'(len_eff);
      end else if (is_flush) begin
         pend_in = '0;
         pcnt_in = '0;
      end
   end

   assign emit_total = total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         pcnt_ff  <= '0;
         total_ff <= '0;
      end else if (advance) begin
         pend_ff  <= pend_in;
         pcnt_ff  <= pcnt_in;
         total_ff <= total_in;
      end
   end

   `HCBP_ASSERT(a_flush_clears, advance && is_flush |=> pcnt_ff == '0 && pend_ff == '0, "flush left pending bits")
   `HCBP_NEVER(a_byte_count, emit_req.take && nbytes > NBYTE_W'(4), "more than four bytes from one item")

endmodule

/* hdl/hcbp_emit.sv */
// byte emitter: shifts bytes out of the window into the result register
`include "assert_macros.svh"

module hcbp_emit #(
   parameter int CODE_W = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hcbp_pkg::emit_req_type        emit_req,
   input  logic [CODE_W+6:0]             emit_win,
   input  logic [hcbp_pkg::TOTAL_W-1:0]  emit_total,
   output logic                          emit_free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hcbp_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_last,
   output logic [hcbp_pkg::TOTAL_W-1:0]  rsp_total_bits
);
   import hcbp_pkg::*;

   localparam int WIN_W = CODE_W + PEND_W;

   logic [WIN_W-1:0]   win_ff;
   logic [NBYTE_W-1:0] left_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic               last_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   logic               out_move;
   logic               shift;

   assign out_move  = !rsp_valid_ff || rsp_ready;
   assign shift     = left_ff != '0 && out_move;
   assign emit_free = left_ff == '0 || (left_ff == NBYTE_W'(1) && out_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (emit_req.take) begin
         left_ff <= emit_req.nbytes;
      end else if (shift) begin
         left_ff <= left_ff - NBYTE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (emit_req.take) begin
         win_ff   <= emit_win;
         total_ff <= emit_total;
      end else if (shift) begin
         win_ff <= win_ff << BYTE_W;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (shift) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         byte_ff      <= win_ff[WIN_W-1 -: BYTE_W];
         last_ff      <= left_ff == NBYTE_W'(1);
         rsp_total_ff <= total_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_last       = last_ff;
   assign rsp_total_bits = rsp_total_ff;

   `HCBP_ASSERT(a_take_when_free, emit_req.take |-> emit_free, "emitter loaded while bytes remain")
   `HCBP_NEVER(a_left_range, left_ff > NBYTE_W'(4), "emitter byte count out of range")

endmodule

/* hdl/huffman_code_bit_packer_top.sv */
// huffman code bit packer: code table lookup, bit accumulator and byte emitter
//
// Input channel req_*: cmd 0 loads code and length of a symbol into the table,
// cmd 1 encodes a symbol, cmd 2 pads pending bits with zeros to a byte.
// Result channel rsp_*: one packed byte per transfer, earliest bit in the msb,
// rsp_last on the final byte of an item, rsp_total_bits the running bit count.
// The first byte of an item passes the table read at the request transfer,
// the emitter load and the result register before it is on rsp_*.
// Throughput: one item per cycle while each item gives at most one byte and
// rsp_ready is not held low; an encode that completes n bytes (up to 4 with
// 32-bit codes) holds the one-byte-per-cycle emitter until all are out.
// A load may be followed directly by an encode of the same symbol.
// Reset clears the pending bits, the bit count and the valid bits of the
// length table, so every symbol reads as length zero until loaded; no
// clearing pass is needed.
// A stall on rsp_ready holds the result register; the emitter and then the
// lookup stage fill up and req_ready drops until the result moves.
module huffman_code_bit_packer_top #(
   parameter int MAX_CODE_LEN = 32,
   parameter int NUM_SYMBOLS  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_symbol,
   input  logic [31:0] req_code_word,
   input  logic [5:0]  req_code_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic [31:0] rsp_total_bits
);
   import hcbp_pkg::*;

   localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
   localparam int LEN_W  = $clog2(CODE_W + 1);

   lookup_type         lookup;
   logic [CODE_W-1:0]  lookup_code;
   logic [LEN_W-1:0]   lookup_len;
   logic               advance;
   logic               emit_free;
   emit_req_type       emit_req;
   logic [CODE_W+6:0]  emit_win;
   logic [TOTAL_W-1:0] emit_total;

   hcbp_table #(
      .NUM_SYMBOLS (NUM_SYMBOLS),
      .CODE_W      (CODE_W),
      .LEN_W       (LEN_W)
   ) u_table (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .advance         (advance),
      .lookup          (lookup),
      .lookup_code     (lookup_code),
      .lookup_len      (lookup_len)
   );

   hcbp_pack #(
      .CODE_W (CODE_W),
      .LEN_W  (LEN_W)
   ) u_pack (
      .clock       (clock),
      .reset       (reset),
      .lookup      (lookup),
      .lookup_code (lookup_code),
      .lookup_len  (lookup_len),
      .emit_free   (emit_free),
      .advance     (advance),
      .emit_req    (emit_req),
      .emit_win    (emit_win),
      .emit_total  (emit_total)
   );

   hcbp_emit #(
      .CODE_W (CODE_W)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .emit_req       (emit_req),
      .emit_win       (emit_win),
      .emit_total     (emit_total),
      .emit_free      (emit_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_total_bits (rsp_total_bits)
   );

endmodule

/* tb/huffman_code_bit_packer_top_tb.sv */
// testbench of the huffman code bit packer: directed and random items checked against a predictor
`timescale 1ns / 1ps

module huffman_code_bit_packer_top_tb;
   import hcbp_pkg::*;

   localparam int MAX_CODE_LEN = 32;
   localparam int NUM_SYMBOLS  = 256;
   localparam int CODE_LIMIT   = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_TAIL   = 12;
   localparam int FULL_HOLD    = 120;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        last;
      logic [31:0] total_bits;
   } packed_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_LOAD;
   logic [7:0]  req_symbol = '0;
   logic [31:0] req_code_word = '0;
   logic [5:0]  req_code_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic [31:0] rsp_total_bits;

   // predictor state
   bit [31:0] code_table [NUM_SYMBOLS];
   bit [5:0]  length_table [NUM_SYMBOLS];
   bit [6:0]  pending_bits;
   bit [2:0]  pending_count;
   bit [31:0] bit_total;
   packed_byte_type expected_bytes [$];

   // symbols whose code has been loaded; only these are encoded
   bit         symbol_loaded [NUM_SYMBOLS];
   logic [7:0] loaded_syms [$];

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned rsp_hold_cycles = 0;
   int unsigned mismatch_count = 0;

   huffman_code_bit_packer_top #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .NUM_SYMBOLS  (NUM_SYMBOLS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_total_bits  (rsp_total_bits)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // appends one byte to the end of the expected queue
   function automatic void add_expected(input packed_byte_type res);
      expected_bytes.insert(expected_bytes.size(), res);
   endfunction

   // works out the bytes one accepted item emits and queues them
   function automatic void pack_code_bits(input logic [1:0] cmd, input logic [7:0] symbol,
                                          input logic [31:0] word, input logic [5:0] length);
      logic [63:0]     acc;
      int unsigned     len;
      int unsigned     count;
      packed_byte_type res;
      case (cmd)
         CMD_LOAD: begin
            code_table[symbol] = word;
            length_table[symbol] = length;
         end
         CMD_ENCODE: begin
            len = length_table[symbol];
            if (len > CODE_LIMIT) len = CODE_LIMIT;
            if (len != 0) begin
               acc = (64'(pending_bits) << len)
                   | (64'(code_table[symbol]) & ((64'd1 << len) - 64'd1));
               count = pending_count + len;
               bit_total = bit_total + len;
               while (count >= BYTE_W) begin
                  count = count - BYTE_W;
                  res.out_byte = 8'(acc >> count);
                  res.last = (count < BYTE_W);
                  res.total_bits = bit_total;
                  add_expected(res);
               end
               pending_bits = 7'(acc & ((64'd1 << count) - 64'd1));
               pending_count = 3'(count);
            end
         end
         CMD_FLUSH: begin
            if (pending_count != 0) begin
               res.out_byte = 8'({1'b0, pending_bits} << (BYTE_W - pending_count));
               res.last = 1'b1;
               res.total_bits = bit_total;
               add_expected(res);
               pending_bits = '0;
               pending_count = '0;
            end
         end
         default: ;
      endcase
   endfunction

   // offers one item from a falling edge and returns at the edge that takes it
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] symbol,
                            input logic [31:0] word, input logic [5:0] length);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_symbol <= symbol;
      req_code_word <= word;
      req_code_length <= length;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pack_code_bits(cmd, symbol, word, length);
      if (cmd == CMD_LOAD && !symbol_loaded[symbol]) begin
         symbol_loaded[symbol] = 1'b1;
         loaded_syms.insert(loaded_syms.size(), symbol);
      end
   endtask

   // encode and flush ignore word and length, so those carry junk
   task automatic send_encode(input logic [7:0] symbol);
      send_item(CMD_ENCODE, symbol, $urandom, 6'($urandom));
   endtask

   task automatic send_flush();
      send_item(CMD_FLUSH, 8'($urandom), $urandom, 6'($urandom));
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_flush();                                   // nothing pending yet
      send_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      send_item(CMD_LOAD, 8'h00, 32'h0000_0001, 6'd1);
      send_item(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
      send_item(CMD_LOAD, 8'h5A, 32'h0000_0000, 6'd0);
      send_item(CMD_LOAD, 8'hA5, 32'h1234_5678, 6'd63);   // clamps to the code limit
      send_item(CMD_LOAD, 8'h80, 32'h0000_00AA, 6'd8);
      send_item(CMD_LOAD, 8'h3C, 32'h0000_0005, 6'd3);
      send_encode(8'h5A);                             // zero length emits nothing
      send_encode(8'h00);
      send_encode(8'h3C);                             // still under a byte
      send_flush();
      send_flush();
      send_encode(8'h80);
      send_encode(8'hFF);
      send_encode(8'h00);
      send_encode(8'hFF);
      send_encode(8'hA5);
      // load directly followed by an encode of the same symbol
      send_item(CMD_LOAD, 8'h00, 32'h0000_001F, 6'd5);
      send_encode(8'h00);
      send_item(CMD_LOAD, 8'h01, 32'hDEAD_BEEF, 6'd33);
      send_encode(8'h01);
      send_flush();
      wait_for_drain();
   endtask

   task automatic test_random_stream(input int unsigned n_items);
      int unsigned sent;
      int unsigned pick;
      int unsigned len_pick;
      logic [5:0]  len;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (loaded_syms.size() == 0 || pick < 12) begin
            len_pick = $urandom_range(99);
            if (len_pick < 8) len = 6'd0;
            else if (len_pick < 18) len = 6'($urandom_range(63, 33));
            else if (len_pick < 35) len = 6'($urandom_range(32, 17));
            else len = 6'($urandom_range(16, 1));
            send_item(CMD_LOAD, 8'($urandom_range(255)), $urandom, len);
            sent++;
         end else if (pick < 82) begin
            send_encode(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
            sent++;
         end else if (pick < 96) begin
            send_flush();
            sent++;
         end else begin
            send_item(CMD_UNUSED, 8'($urandom), $urandom, 6'($urandom));
         end
      end
      wait_for_drain();
   endtask

   // receiver holds off while long codes keep coming, so the input backs up
   task automatic test_full_stall();
      int unsigned i;
      send_item(CMD_LOAD, 8'h11, $urandom, 6'd32);
      send_item(CMD_LOAD, 8'h22, $urandom, 6'd20);
      send_item(CMD_LOAD, 8'h33, $urandom, 6'd13);
      rsp_hold_cycles = FULL_HOLD;
      for (i = 0; i < 24; i++) begin
         case (i % 3)
            0: send_encode(8'h11);
            1: send_encode(8'h22);
            default: send_encode(8'h33);
         endcase
      end
      send_flush();
      wait_for_drain();
   endtask

   initial begin : result_sink
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : result_check
      packed_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected transfer, byte %02h last %0d total %0d",
                     $time, rsp_out_byte, rsp_last, rsp_total_bits);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, want.out_byte, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch: expected %0d, actual %0d",
                        $time, want.last, rsp_last);
               mismatch_count++;
            end
            if (rsp_total_bits !== want.total_bits) begin
               $display("%0t: total_bits mismatch: expected %0d, actual %0d",
                        $time, want.total_bits, rsp_total_bits);
               mismatch_count++;
            end
         end
      end
   end

   // ends the run when no transfer happens on either side for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      @(negedge reset);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("huffman_code_bit_packer_top_tb NOT OK");
      $finish;
   end

   initial begin : main
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 17;
      rsp_idle_pct = 54;
      test_directed();
      test_random_stream(35);

      req_idle_pct = 54;
      rsp_idle_pct = 17;
      test_random_stream(35);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_stream(35);
      test_full_stall();

      wait_for_drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("huffman_code_bit_packer_top_tb OK");
      end else begin
         $display("huffman_code_bit_packer_top_tb NOT OK");
      end
      $finish;
   end

endmodule
